@@ rtl/core/wlmpf_pkg.sv @@
// ----------------------------------------------------------------------------
// wlmpf_pkg
// shared types and constants of the windowed local-maximum peak finder
// ----------------------------------------------------------------------------
package wlmpf_pkg;

	// widest half window and the window that follows from it
	localparam int MAX_HW      = 8;
	localparam int WIN_DEPTH   = 2 * MAX_HW + 1;
	localparam int HW_W        = 4;
	localparam int SLOT_W      = $clog2(MAX_HW);
	localparam int DATA_W      = 32;
	localparam int IDX_W       = 16;
	localparam logic [IDX_W-1:0] IDX_MAX = {IDX_W{1'b1}};

	// queue between classifier and emitter
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// register map
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_HEIGHT = 1'b1;
	localparam logic [HW_W-1:0]   HALF_WIDTH_RESET = 4'd3;
	localparam logic [DATA_W-1:0] MIN_HEIGHT_RESET = 32'd5120;

	typedef struct packed {
		logic signed [DATA_W-1:0] sample;
		logic                     last_sample;
	} in_item_t;

	typedef struct packed {
		logic [IDX_W-1:0]         peak_index;
		logic signed [DATA_W-1:0] peak_value;
		logic                     trace_done;
	} out_item_t;

	// one classified item: bit k-1 of peak_mask marks the centre k back from newest
	typedef struct packed {
		logic [MAX_HW-1:0]             peak_mask;
		logic [MAX_HW-1:0][DATA_W-1:0] centre_values;
		logic [IDX_W-1:0]              position;
		logic                          last_sample;
	} qentry_t;

endpackage

@@ rtl/core/wlmpf_front.sv @@
// ----------------------------------------------------------------------------
// wlmpf_front
// sample window, trace position and parallel peak classification
// ----------------------------------------------------------------------------
module wlmpf_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 sample_valid,
	output logic                                 sample_stall,
	input  wlmpf_pkg::in_item_t                  sample_item,
	input  logic [wlmpf_pkg::HW_W-1:0]           hw_eff,
	input  logic signed [wlmpf_pkg::DATA_W-1:0]  min_height,
	input  logic                                 q_full,
	output logic                                 q_push,
	output wlmpf_pkg::qentry_t                   q_entry
);

	logic signed [wlmpf_pkg::DATA_W-1:0] win_q [wlmpf_pkg::WIN_DEPTH];
	logic [wlmpf_pkg::IDX_W-1:0]         count_q;
	logic                                valid_s1;
	logic [wlmpf_pkg::IDX_W-1:0]         pos_s1;
	logic                                last_s1;
	logic [wlmpf_pkg::MAX_HW-1:0]        mask;
	logic                                need_push;
	logic                                accept;

	assign need_push    = valid_s1 && ((mask != '0) || last_s1);
	assign sample_stall = need_push && q_full;
	assign accept       = sample_valid && !sample_stall;
	assign q_push       = need_push && !q_full;

	// window shifts only on accept, so it always matches the item in s1
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = wlmpf_pkg::WIN_DEPTH - 1; i > 0; i--) begin
				win_q[i] <= win_q[i-1];
			end
			win_q[0] <= sample_item.sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
			pos_s1   <= '0;
		end else if (!sample_stall) begin
			valid_s1 <= accept;
			if (accept) begin
				pos_s1  <= count_q;
				last_s1 <= sample_item.last_sample;
				if (sample_item.last_sample) begin
					count_q <= '0;
				end else if (count_q != wlmpf_pkg::IDX_MAX) begin
					count_q <= count_q + 1'b1;
				end
			end
		end
	end

	// every candidate centre is judged at once
	always_comb begin
		logic ok;
		logic signed [wlmpf_pkg::DATA_W-1:0] c;
		logic signed [wlmpf_pkg::DATA_W-1:0] l;
		logic signed [wlmpf_pkg::DATA_W-1:0] r;
		mask = '0;
		for (int k = 1; k <= wlmpf_pkg::MAX_HW; k++) begin
			c  = win_q[k];
			l  = win_q[k+1];
			r  = win_q[k-1];
			ok = last_s1 ? (wlmpf_pkg::HW_W'(k) <= hw_eff) : (wlmpf_pkg::HW_W'(k) == hw_eff);
			ok = ok && (pos_s1 >= wlmpf_pkg::IDX_W'(k + 1));
			// slope sign drops at the centre
			ok = ok && (c >= l) && (c >= r) && !((c == l) && (c == r));
			// left window, clipped at the trace start
			for (int j = 1; j <= wlmpf_pkg::MAX_HW; j++) begin
				if ((wlmpf_pkg::HW_W'(j) <= hw_eff) && (pos_s1 >= wlmpf_pkg::IDX_W'(k + j))
						&& (win_q[k+j] > c)) begin
					ok = 1'b0;
				end
			end
			// right window, clipped at the newest sample
			for (int j = 1; j <= k; j++) begin
				if ((wlmpf_pkg::HW_W'(j) <= hw_eff) && (win_q[k-j] > c)) begin
					ok = 1'b0;
				end
			end
			mask[k-1] = ok && (c >= min_height);
		end
	end

	always_comb begin
		q_entry.peak_mask   = mask;
		q_entry.position    = pos_s1;
		q_entry.last_sample = last_s1;
		for (int k = 1; k <= wlmpf_pkg::MAX_HW; k++) begin
			q_entry.centre_values[k-1] = win_q[k];
		end
	end

endmodule

@@ rtl/core/wlmpf_queue.sv @@
// ----------------------------------------------------------------------------
// wlmpf_queue
// short first-in first-out queue of classified items
// ----------------------------------------------------------------------------
module wlmpf_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  wlmpf_pkg::qentry_t push_entry,
	input  logic               pop,
	output logic               full,
	output logic               not_empty,
	output wlmpf_pkg::qentry_t head_entry
);

	wlmpf_pkg::qentry_t                 mem_q [wlmpf_pkg::QUEUE_DEPTH];
	logic [wlmpf_pkg::QPTR_W-1:0]       wr_ptr_q;
	logic [wlmpf_pkg::QPTR_W-1:0]       rd_ptr_q;
	logic [wlmpf_pkg::QCNT_W-1:0]       count_q;

	assign full       = (count_q == wlmpf_pkg::QCNT_W'(wlmpf_pkg::QUEUE_DEPTH));
	assign not_empty  = (count_q != '0);
	assign head_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/core/wlmpf_back.sv @@
// ----------------------------------------------------------------------------
// wlmpf_back
// walks each queued item and emits its peaks and the done item
// ----------------------------------------------------------------------------
module wlmpf_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	input  wlmpf_pkg::qentry_t   head_entry,
	output logic                 q_pop,
	output logic                 result_valid,
	input  logic                 result_stall,
	output wlmpf_pkg::out_item_t result_item
);

	logic [wlmpf_pkg::MAX_HW-1:0]   served_q;
	logic [wlmpf_pkg::MAX_HW-1:0]   remaining;
	logic [wlmpf_pkg::MAX_HW-1:0]   sel_onehot;
	logic [wlmpf_pkg::HW_W-1:0]     sel_k;
	logic [wlmpf_pkg::SLOT_W-1:0]   sel_slot;
	logic                           load;
	logic                           out_valid_q;
	wlmpf_pkg::out_item_t           out_q;
	wlmpf_pkg::out_item_t           next_item;
	logic                           last_peak;

	assign remaining = head_entry.peak_mask & ~served_q;
	assign load      = q_valid && (!out_valid_q || !result_stall);

	// highest remaining centre is the oldest position
	always_comb begin
		sel_onehot = '0;
		sel_k      = '0;
		sel_slot   = '0;
		for (int k = 1; k <= wlmpf_pkg::MAX_HW; k++) begin
			if (remaining[k-1]) begin
				sel_onehot = wlmpf_pkg::MAX_HW'(1) << (k - 1);
				sel_k      = wlmpf_pkg::HW_W'(k);
				sel_slot   = wlmpf_pkg::SLOT_W'(k - 1);
			end
		end
	end

	assign last_peak = ((remaining & ~sel_onehot) == '0) && !head_entry.last_sample;

	always_comb begin
		next_item = '0;
		if (remaining != '0) begin
			next_item.peak_index = (head_entry.position == wlmpf_pkg::IDX_MAX) ?
				wlmpf_pkg::IDX_MAX :
				head_entry.position - wlmpf_pkg::IDX_W'(sel_k);
			next_item.peak_value = head_entry.centre_values[sel_slot];
		end else begin
			next_item.trace_done = 1'b1;
		end
	end

	assign q_pop = load && ((remaining == '0) || last_peak);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			served_q    <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				served_q    <= q_pop ? '0 : (served_q | sel_onehot);
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= next_item;
		end
	end

	assign result_valid = out_valid_q;
	assign result_item  = out_q;

endmodule

@@ rtl/core/windowed_local_max_peak_finder_core.sv @@
// ----------------------------------------------------------------------------
// windowed_local_max_peak_finder_core
// streaming local-maximum peak finder over a trace of signed q23.8 samples
// ----------------------------------------------------------------------------
//  channel   direction  handshake                   payload
//  sample    in         sample_valid/sample_stall   sample_item (sample, last_sample)
//  result    out        result_valid/result_stall   result_item (peak_index, peak_value,
//                                                               trace_done)
//  cfg       in         cfg_we                      cfg_index, cfg_data
//
//  one sample per cycle is taken while sample_stall is low; an ordinary sample gives at most one item
//  a last sample gives up to the effective half width of peak items then the done item,
//  one a cycle while result_stall is low, set by the single output register of the emitter
//  an accepted sample passes the front s1 register, the queue and the emitter output register
//  arst_n clears control state and position and loads the config reset values; window contents need no reset
//  result_stall backs up through the four-entry queue into sample_stall
// ----------------------------------------------------------------------------
module windowed_local_max_peak_finder_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                sample_valid,
	output logic                                sample_stall,
	input  wlmpf_pkg::in_item_t                 sample_item,
	output logic                                result_valid,
	input  logic                                result_stall,
	output wlmpf_pkg::out_item_t                result_item,
	input  logic                                cfg_we,
	input  logic [wlmpf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [wlmpf_pkg::DATA_W-1:0]        cfg_data
);

	// configuration registers
	logic [wlmpf_pkg::HW_W-1:0]          half_width_q;
	logic signed [wlmpf_pkg::DATA_W-1:0] min_height_q;
	logic [wlmpf_pkg::HW_W-1:0]          hw_eff;

	// front to queue to back
	logic                 q_push;
	logic                 q_pop;
	logic                 q_full;
	logic                 q_not_empty;
	wlmpf_pkg::qentry_t   push_entry;
	wlmpf_pkg::qentry_t   head_entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_width_q <= wlmpf_pkg::HALF_WIDTH_RESET;
			min_height_q <= wlmpf_pkg::MIN_HEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				wlmpf_pkg::REG_HALF_WIDTH: half_width_q <= cfg_data[wlmpf_pkg::HW_W-1:0];
				wlmpf_pkg::REG_MIN_HEIGHT: min_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// zero half width acts as one, anything above the window limit is clamped
	always_comb begin
		hw_eff = half_width_q;
		if (half_width_q == '0) begin
			hw_eff = wlmpf_pkg::HW_W'(1);
		end else if (half_width_q > wlmpf_pkg::HW_W'(wlmpf_pkg::MAX_HW)) begin
			hw_eff = wlmpf_pkg::HW_W'(wlmpf_pkg::MAX_HW);
		end
	end

	// front: window shift, position count and parallel classification
	wlmpf_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample_item  (sample_item),
		.hw_eff       (hw_eff),
		.min_height   (min_height_q),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_entry      (push_entry)
	);

	// only items that yield results enter the queue
	wlmpf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (push_entry),
		.pop        (q_pop),
		.full       (q_full),
		.not_empty  (q_not_empty),
		.head_entry (head_entry)
	);

	// back: one result item a cycle while result_stall is low, oldest peak first, done item closes a trace
	wlmpf_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_not_empty),
		.head_entry   (head_entry),
		.q_pop        (q_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_item  (result_item)
	);

endmodule

@@ test/tb_windowed_local_max_peak_finder_core.sv @@
// ----------------------------------------------------------------------------
// tb_windowed_local_max_peak_finder_core
// self-checking bench: traces of q23.8 samples go in through the sample
// channel, a local-maximum predictor inside the bench works out the peak and
// done items that each accepted sample causes, and every result item is
// compared field by field against the oldest item still owed
// ----------------------------------------------------------------------------
module tb_windowed_local_max_peak_finder_core;

	import wlmpf_pkg::*;

	// q23.8 unit and the sample extremes
	localparam logic signed [DATA_W-1:0] ONE        = 32'sd256;
	localparam logic signed [DATA_W-1:0] SAMPLE_MIN = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] SAMPLE_MAX = 32'sh7FFF_FFFF;

	// run shaping
	localparam int RANDOM_ITEMS  = 170;
	localparam int SETTLE_CYCLES = 12;   // time for the pipeline registers and the queue to drain, with margin
	localparam int STALL_LIMIT   = 4000; // cycles with no item moving on either channel
	localparam int MAX_REPORTS   = 30;

	typedef enum int {SHAPE_SPIKY, SHAPE_PLATEAU, SHAPE_NOISE} trace_shape_t;

	// clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// block ports, all known from time zero
	logic                    sample_valid = 1'b0;
	logic                    sample_stall;
	in_item_t                sample_item  = '0;
	logic                    result_valid;
	logic                    result_stall = 1'b0;
	out_item_t               result_item;
	logic                    cfg_we       = 1'b0;
	logic [CFG_IDX_W-1:0]    cfg_index    = '0;
	logic [DATA_W-1:0]       cfg_data     = '0;

	windowed_local_max_peak_finder_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample_item  (sample_item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_item  (result_item),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// predictor state: register copies, trace window (newest first), trace position
	logic [HW_W-1:0]          hw_cfg         = HALF_WIDTH_RESET;
	logic signed [DATA_W-1:0] min_height_cfg = MIN_HEIGHT_RESET;
	logic signed [DATA_W-1:0] trace_window [WIN_DEPTH] = '{default: '0};
	int                       trace_pos      = 0;

	// result items owed by the block, oldest first
	out_item_t peak_reports_due [$];

	// pacing knobs, percent chance per item or per cycle
	int send_gap_pct = 0;
	int stall_pct    = 0;
	int stall_left   = 0;

	int fail_count   = 0;
	int random_items = 0;

	// samples of the next trace to send
	logic signed [DATA_W-1:0] trace_buf [$];

	// mostly short gaps, now and then a long one
	function automatic int idle_len();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(8, 40);
		return $urandom_range(1, 3);
	endfunction

	// half width zero acts as one, above the window limit it saturates
	function automatic int eff_half_width();
		int h;
		h = hw_cfg;
		if (h < 1)
			h = 1;
		if (h > MAX_HW)
			h = MAX_HW;
		return h;
	endfunction

	// centre k back from the newest sample, newest sample at trace position p
	function automatic bit centre_is_peak(int k, int p, int hw);
		logic signed [DATA_W-1:0] c;
		int j;
		if (k < 1 || k + 1 > p || k + hw >= WIN_DEPTH)
			return 1'b0;
		c = trace_window[k];
		// slope sign must drop: not below either neighbour, not flat on both sides
		if (c < trace_window[k+1] || c < trace_window[k-1])
			return 1'b0;
		if (c == trace_window[k+1] && c == trace_window[k-1])
			return 1'b0;
		// left window, clipped at the trace start
		for (j = k + 1; j <= k + hw && j <= p; j++)
			if (trace_window[j] > c)
				return 1'b0;
		// right window, clipped by what has arrived
		for (j = 1; j <= hw && j <= k; j++)
			if (trace_window[k-j] > c)
				return 1'b0;
		return c >= min_height_cfg;
	endfunction

	// one accepted sample: shift it in, judge centres whose right window is complete, or all on a last sample
	task automatic judge_sample(input logic signed [DATA_W-1:0] s, input logic last);
		int p;
		int hw;
		int k;
		int k_low;
		out_item_t r;
		p = trace_pos;
		hw = eff_half_width();
		k_low = last ? 1 : hw;
		for (k = WIN_DEPTH - 1; k > 0; k--)
			trace_window[k] = trace_window[k-1];
		trace_window[0] = s;
		// on the last sample every pending centre is flushed, oldest first
		for (k = hw; k >= k_low; k--) begin
			if (centre_is_peak(k, p, hw)) begin
				r.peak_index = (p >= int'(IDX_MAX)) ? IDX_MAX : IDX_W'(p - k);
				r.peak_value = trace_window[k];
				r.trace_done = 1'b0;
				peak_reports_due.insert(peak_reports_due.size(), r);
			end
		end
		if (last) begin
			r = '0;
			r.trace_done = 1'b1;
			peak_reports_due.insert(peak_reports_due.size(), r);
			trace_pos = 0;
		end else if (trace_pos < int'(IDX_MAX)) begin
			trace_pos++;
		end
	endtask

	// offer one item, hold it until taken, then predict what it causes
	task automatic offer_sample(input logic signed [DATA_W-1:0] s, input logic last);
		in_item_t item;
		int gap;
		item.sample = s;
		item.last_sample = last;
		gap = ($urandom_range(0, 99) < send_gap_pct) ? idle_len() : 0;
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample_item <= item;
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
		judge_sample(s, last);
	endtask

	// drop valid, wait for every owed item, then give the pipeline time to empty
	task automatic settle();
		sample_valid <= 1'b0;
		while (peak_reports_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// register write, only called while the block is idle
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == REG_HALF_WIDTH)
			hw_cfg = data[HW_W-1:0];
		else
			min_height_cfg = data;
	endtask

	// half width write with junk in the unused upper bits
	task automatic write_half_width(input logic [HW_W-1:0] hw);
		logic [DATA_W-1:0] data;
		data = $urandom;
		data[HW_W-1:0] = hw;
		write_reg(REG_HALF_WIDTH, data);
	endtask

	// send trace_buf as one trace, last flag on its final sample
	task automatic send_trace();
		int i;
		for (i = 0; i < trace_buf.size(); i++)
			offer_sample(trace_buf[i], i == trace_buf.size() - 1);
		settle();
	endtask

	// reset config: plateau edges, flat tops, below-threshold bumps, extremes,
	// a peak inside the clipped right window at the end, and the short traces
	task automatic test_default_config();
		send_gap_pct = 20;
		stall_pct = 15;
		trace_buf = '{24*ONE, 40*ONE, 40*ONE, 40*ONE, 12*ONE, SAMPLE_MIN, 18*ONE,
			3*ONE, SAMPLE_MAX, 50*ONE};
		send_trace();
		// single sample and two samples give only the done item
		trace_buf = '{SAMPLE_MAX};
		send_trace();
		trace_buf = '{0, SAMPLE_MAX};
		send_trace();
		// shortest trace that can hold a peak
		trace_buf = '{0, 100*ONE, 0};
		send_trace();
	endtask

	// half width zero acts as neighbours only; fifteen saturates to the full window
	task automatic test_half_width_extremes();
		write_half_width(4'd0);
		write_reg(REG_MIN_HEIGHT, SAMPLE_MIN);
		trace_buf = '{5*ONE, 1*ONE, 5*ONE, 1*ONE, 5*ONE};
		send_trace();
		write_half_width(4'd15);
		write_reg(REG_MIN_HEIGHT, SAMPLE_MAX);
		trace_buf = '{0, SAMPLE_MAX, SAMPLE_MAX - 1, SAMPLE_MAX, 0};
		send_trace();
	endtask

	// new random settings between traces, extremes weighted up
	task automatic shuffle_config();
		int pick;
		if ($urandom_range(0, 9) < 4) begin
			pick = $urandom_range(0, 5);
			case (pick)
				0: write_half_width(4'd0);
				1: write_half_width(4'd1);
				2: write_half_width(4'd8);
				3: write_half_width(4'd15);
				default: write_half_width(HW_W'($urandom_range(0, 15)));
			endcase
		end
		if ($urandom_range(0, 9) < 4) begin
			pick = $urandom_range(0, 7);
			case (pick)
				0: write_reg(REG_MIN_HEIGHT, SAMPLE_MIN);
				1: write_reg(REG_MIN_HEIGHT, SAMPLE_MAX);
				2: write_reg(REG_MIN_HEIGHT, $urandom);
				default: write_reg(REG_MIN_HEIGHT, $urandom_range(0, 48) * ONE - 16 * ONE);
			endcase
		end
	endtask

	// random trace into trace_buf: spiky shapes, plateaus with ties, or raw noise
	task automatic build_random_trace();
		int len;
		int i;
		int scale;
		int pick;
		trace_shape_t shape;
		logic signed [DATA_W-1:0] base;
		logic signed [DATA_W-1:0] next_sample;
		pick = $urandom_range(0, 19);
		if (pick == 0)
			len = $urandom_range(1, 2);
		else if (pick == 1)
			len = $urandom_range(40, 60);
		else
			len = $urandom_range(3, 24);
		pick = $urandom_range(0, 9);
		shape = (pick < 6) ? SHAPE_SPIKY : (pick < 8) ? SHAPE_PLATEAU : SHAPE_NOISE;
		// most traces sit near zero so peaks clear typical thresholds
		if ($urandom_range(0, 9) < 6)
			base = $urandom_range(0, 40) * ONE - 8 * ONE;
		else
			base = $urandom;
		trace_buf.delete();
		for (i = 0; i < len; i++) begin
			case (shape)
				SHAPE_SPIKY: begin
					scale = ($urandom_range(0, 3) == 0) ? 4 : 1;
					next_sample = base + scale * $urandom_range(0, 15) * ONE
						+ $urandom_range(0, 255);
				end
				SHAPE_PLATEAU:
					next_sample = base + $urandom_range(0, 2) * ONE;
				default:
					next_sample = $urandom;
			endcase
			trace_buf.insert(trace_buf.size(), next_sample);
		end
	endtask

	// random traces under changing settings and pacing
	task automatic test_random_traces();
		int pace;
		while (random_items < RANDOM_ITEMS) begin
			shuffle_config();
			pace = $urandom_range(0, 3);
			// some traces run with no gaps or stalls at all
			if (pace == 0) begin
				send_gap_pct = 0;
				stall_pct = 0;
			end else if (pace == 1) begin
				send_gap_pct = 50;
				stall_pct = 50;
			end else begin
				send_gap_pct = 20;
				stall_pct = 15;
			end
			build_random_trace();
			random_items += trace_buf.size();
			send_trace();
		end
	endtask

	// result side back-pressure
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
			if ($urandom_range(0, 99) < stall_pct)
				stall_left = idle_len();
		end
	end

	task automatic report_mismatch(input string field, input longint want, input longint got);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$error("%s: expected %0d, got %0d", field, want, got);
	endtask

	// every accepted result against the oldest owed item
	always @(posedge clk) begin : result_check
		out_item_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (peak_reports_due.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$error("result item with none owed: index %0d value %0d done %0b",
						result_item.peak_index, result_item.peak_value,
						result_item.trace_done);
			end else begin
				want = peak_reports_due.pop_front();
				if (result_item.peak_index !== want.peak_index)
					report_mismatch("peak_index", want.peak_index, result_item.peak_index);
				if (result_item.peak_value !== want.peak_value)
					report_mismatch("peak_value", want.peak_value, result_item.peak_value);
				if (result_item.trace_done !== want.trace_done)
					report_mismatch("trace_done", want.trace_done, result_item.trace_done);
			end
		end
	end

	// give up when nothing moves on either channel for too long
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((sample_valid && !sample_stall) || (result_valid && !result_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_config();
		test_half_width_extremes();
		test_random_traces();
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
